>>> rtl/thf_pkg.sv
package thf_pkg;

  // Converter and divider
  localparam int ADC_BITS = 10;
  localparam int SR_W     = 17;
  localparam logic [SR_W-1:0] SR_RESET = 17'd10100;
  localparam int REF_OHMS = 10000;
  localparam int NUM_W    = SR_W + ADC_BITS;
  localparam int DEN_W    = ADC_BITS + 14;

  // log2 unit: Q30 mantissa, 24 fraction bits by repeated squaring
  localparam int LOG_IN_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int EXP_W     = $clog2(LOG_IN_W);
  localparam int MANT_W    = 31;
  localparam int FRAC_BITS = 24;
  localparam int LOG_W     = EXP_W + FRAC_BITS;

  // ln = (log2 num - log2 den) * ln2, Q32 constant, >> 40 with floor
  localparam int LN2_W = 32;
  localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam int LN_SHIFT  = 40;
  localparam int LN_PROD_W = LOG_W + 1 + LN2_W + 1;
  localparam int LN_W      = 22;

  // Steinhart-Hart cubic, Q0.40 coefficients
  localparam int T_W          = 36;
  localparam int HORNER_SHIFT = 16;
  localparam logic signed [T_W-1:0] SH_A = 36'sd3687779592;
  localparam logic signed [T_W-1:0] SH_B = 36'sd282557996;
  localparam logic signed [T_W-1:0] SH_C = 36'sd2880865;
  localparam logic signed [T_W-1:0] SH_D = 36'sd70183;

  // Reciprocal: q = (180 << 56) / t, 41 quotient bits
  localparam int DVS_W = T_W - 1;
  localparam int Q_W   = 41;
  localparam logic [DVS_W-1:0] REM_INIT = 35'd5898240;

  // Formatting
  localparam int V_W = Q_W + 1;
  localparam logic [V_W-1:0] OFFSET_Q16 = 42'd3012493312;
  localparam logic [V_W-1:0] ROUND_Q16  = 42'd327680;
  localparam int W_W = 17;
  localparam logic [W_W-1:0] W_LIMIT = 17'd100000;
  localparam int MAG_W = 14;
  localparam logic [MAG_W-1:0] TEMP_LIMIT = 14'd9999;
  localparam int OUT_W = 15;
  localparam int DIG_W = 6;
  localparam logic [DIG_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [17:0] DIV10_MUL = 18'd209716;
  localparam int DIV10_SH = 21;

  // Pipeline depth
  localparam int SQ_N      = FRAC_BITS;
  localparam int IN_ST     = 1;
  localparam int LN_ST     = 1 + SQ_N + 3;
  localparam int POLY_ST   = 6;
  localparam int RECIP_ST  = 1 + Q_W + 1;
  localparam int FMT_ST    = 5;
  localparam int LATENCY   = IN_ST + LN_ST + POLY_ST + RECIP_ST + FMT_ST;

  typedef struct packed {
    logic open;
    logic sat;
  } thf_flags_t;

  typedef struct packed {
    logic [EXP_W-1:0]  e;
    logic [MANT_W-1:0] m;
  } thf_norm_t;

  // Leading-one position and mantissa n * 2^30 / 2^e
  function automatic thf_norm_t norm(input logic [LOG_IN_W-1:0] n);
    thf_norm_t res;
    logic [LOG_IN_W+MANT_W-1:0] wide;
    res.e = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (n[i]) res.e = EXP_W'(i);
    end
    wide = (LOG_IN_W+MANT_W)'(n) << (MANT_W - 1);
    res.m = MANT_W'(wide >> res.e);
    return res;
  endfunction

  // One squaring step: {fraction bit, next mantissa}
  function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] p;
    logic [MANT_W:0] s;
    p = (2*MANT_W)'(m) * (2*MANT_W)'(m);
    s = p[2*MANT_W-1:MANT_W-1];
    if (s[MANT_W]) return {1'b1, s[MANT_W:1]};
    return {1'b0, s[MANT_W-1:0]};
  endfunction

  // Exact x / 10 for any 17-bit x
  function automatic logic [16:0] div10(input logic [16:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'(DIV10_MUL);
    return 17'(p >> DIV10_SH);
  endfunction

endpackage

>>> rtl/thermistor_adc_to_fahrenheit.sv
// Channel      Handshake              Payload
// request in   start / busy           adc_code
// result out   done (one-cycle)       temp_tenths_f, tens_digit, units_digit,
//                                     tenths_digit, sensor_open
// config       wr_en                  wr_data -> series_resistance
//
// One request per clock outside reset. Most of the pipeline lies in the 24 squaring
// stages of the log2 unit and the 41 one-bit stages of the reciprocal divider.
// rst is synchronous and clears the series resistance to 10100 ohms and all
// valid bits; busy is high only during reset.
// The receiver cannot stall, so the pipeline never stops.
module thermistor_adc_to_fahrenheit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [thf_pkg::ADC_BITS-1:0] adc_code,
  input  logic wr_en,
  input  logic [thf_pkg::SR_W-1:0] wr_data,
  output logic done,
  output logic signed [thf_pkg::OUT_W-1:0] temp_tenths_f,
  output logic [thf_pkg::DIG_W-1:0] tens_digit,
  output logic [thf_pkg::DIG_W-1:0] units_digit,
  output logic [thf_pkg::DIG_W-1:0] tenths_digit,
  output logic sensor_open
);

  logic [thf_pkg::SR_W-1:0] series_resistance;
  logic accept;
  logic [thf_pkg::ADC_BITS:0] fc;
  logic [thf_pkg::NUM_W-1:0] num;
  logic [thf_pkg::DEN_W-1:0] den;

  logic v1;
  thf_pkg::thf_flags_t f1;
  logic nz1;
  logic [thf_pkg::LOG_IN_W-1:0] num1, den1;

  logic ln_v, poly_v, recip_v;
  thf_pkg::thf_flags_t ln_f, poly_f, recip_f;
  logic signed [thf_pkg::LN_W-1:0] ln;
  logic signed [thf_pkg::T_W-1:0] t;
  logic [thf_pkg::Q_W-1:0] q;

  // Series resistor register
  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance <= thf_pkg::SR_RESET;
    end else if (wr_en) begin
      series_resistance <= wr_data;
    end
  end

  assign busy   = rst;
  assign accept = start & ~busy;

  // Divider products: num = Rs * (FULL - code), den = code * 10k
  assign fc  = (thf_pkg::ADC_BITS+1)'(1 << thf_pkg::ADC_BITS) - (thf_pkg::ADC_BITS+1)'(adc_code);
  assign num = thf_pkg::NUM_W'(series_resistance) * thf_pkg::NUM_W'(fc);
  assign den = thf_pkg::DEN_W'(adc_code) * thf_pkg::DEN_W'(thf_pkg::REF_OHMS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    f1   <= '{open: (adc_code == '0), sat: 1'b0};
    nz1  <= (num == '0);
    num1 <= thf_pkg::LOG_IN_W'(num);
    den1 <= thf_pkg::LOG_IN_W'(den);
  end

  thf_ln u_ln (
    .clk, .rst,
    .in_valid(v1), .in_flags(f1), .in_num_zero(nz1),
    .num(num1), .den(den1),
    .out_valid(ln_v), .out_flags(ln_f), .ln(ln)
  );

  thf_poly u_poly (
    .clk, .rst,
    .in_valid(ln_v), .in_flags(ln_f), .ln(ln),
    .out_valid(poly_v), .out_flags(poly_f), .t(t)
  );

  thf_recip u_recip (
    .clk, .rst,
    .in_valid(poly_v), .in_flags(poly_f), .t(t),
    .out_valid(recip_v), .out_flags(recip_f), .q(q)
  );

  thf_fmt u_fmt (
    .clk, .rst,
    .in_valid(recip_v), .in_flags(recip_f), .q(q),
    .out_valid(done), .temp(temp_tenths_f),
    .tens(tens_digit), .units(units_digit), .tenths(tenths_digit),
    .open(sensor_open)
  );

  // Every request yields its result at the output of the full pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(thf_pkg::LATENCY) done)
    else $error("result missing after request");

  // Open sensor reports zero and all-zero digits
  a_open: assert property (@(posedge clk) disable iff (rst)
    done && sensor_open |-> (temp_tenths_f == '0) &&
      (tens_digit == thf_pkg::ASCII_ZERO) && (units_digit == thf_pkg::ASCII_ZERO) &&
      (tenths_digit == thf_pkg::ASCII_ZERO))
    else $error("open sensor result not zero");

  // Saturation limits
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (temp_tenths_f <= 15'sd9999) && (temp_tenths_f >= -15'sd9999))
    else $error("temperature out of range");

  // Digits are ASCII decimal
  a_digits: assert property (@(posedge clk) disable iff (rst)
    done |-> (tens_digit >= 6'd48) && (tens_digit <= 6'd57) &&
      (units_digit >= 6'd48) && (units_digit <= 6'd57) &&
      (tenths_digit >= 6'd48) && (tenths_digit <= 6'd57))
    else $error("digit not decimal");

endmodule

>>> rtl/thf_ln.sv
module thf_ln (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  thf_pkg::thf_flags_t in_flags,
  input  logic in_num_zero,
  input  logic [thf_pkg::LOG_IN_W-1:0] num,
  input  logic [thf_pkg::LOG_IN_W-1:0] den,
  output logic out_valid,
  output thf_pkg::thf_flags_t out_flags,
  output logic signed [thf_pkg::LN_W-1:0] ln
);

  localparam int N  = thf_pkg::SQ_N;
  localparam int SW = thf_pkg::LN_PROD_W - thf_pkg::LN_SHIFT;

  // Squaring pipeline, index 0 is the normalize stage
  logic                          vld [0:N];
  thf_pkg::thf_flags_t           flg [0:N];
  logic                          nz  [0:N];
  logic [thf_pkg::EXP_W-1:0]     en  [0:N];
  logic [thf_pkg::EXP_W-1:0]     ed  [0:N];
  logic [thf_pkg::MANT_W-1:0]    mn  [0:N];
  logic [thf_pkg::MANT_W-1:0]    md  [0:N];
  logic [thf_pkg::FRAC_BITS-1:0] fn  [0:N];
  logic [thf_pkg::FRAC_BITS-1:0] fd  [0:N];
  logic [thf_pkg::MANT_W:0]      sqn [1:N];
  logic [thf_pkg::MANT_W:0]      sqd [1:N];
  thf_pkg::thf_norm_t            nn, nd;

  // Tail stages: difference, product, shift and clamp
  logic vd, vp, vc;
  thf_pkg::thf_flags_t fdiff, fprod, fclamp;
  logic nzd, nzp;
  logic signed [thf_pkg::LOG_W:0] diff;
  logic signed [thf_pkg::LN_PROD_W-1:0] prod;
  logic signed [SW-1:0] shv;
  logic [SW-thf_pkg::LN_W:0] hi;
  logic signed [thf_pkg::LN_W-1:0] ln_next;

  always_comb begin
    nn = thf_pkg::norm(num);
    nd = thf_pkg::norm(den);
    for (int i = 1; i <= N; i++) begin
      sqn[i] = thf_pkg::sq_step(mn[i-1]);
      sqd[i] = thf_pkg::sq_step(md[i-1]);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) vld[i] <= 1'b0;
      vd <= 1'b0;
      vp <= 1'b0;
      vc <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i <= N; i++) vld[i] <= vld[i-1];
      vd <= vld[N];
      vp <= vd;
      vc <= vp;
    end
  end

  // Payload of the squaring stages
  always_ff @(posedge clk) begin
    flg[0] <= in_flags;
    nz[0]  <= in_num_zero;
    en[0]  <= nn.e;
    ed[0]  <= nd.e;
    mn[0]  <= nn.m;
    md[0]  <= nd.m;
    fn[0]  <= '0;
    fd[0]  <= '0;
    for (int i = 1; i <= N; i++) begin
      flg[i] <= flg[i-1];
      nz[i]  <= nz[i-1];
      en[i]  <= en[i-1];
      ed[i]  <= ed[i-1];
      mn[i]  <= sqn[i][thf_pkg::MANT_W-1:0];
      md[i]  <= sqd[i][thf_pkg::MANT_W-1:0];
      fn[i]  <= {fn[i-1][thf_pkg::FRAC_BITS-2:0], sqn[i][thf_pkg::MANT_W]};
      fd[i]  <= {fd[i-1][thf_pkg::FRAC_BITS-2:0], sqd[i][thf_pkg::MANT_W]};
    end
  end

  // Floor shift by 40 is a plain drop of low bits; clamp to Q5.16
  always_comb begin
    shv = prod[thf_pkg::LN_PROD_W-1:thf_pkg::LN_SHIFT];
    hi  = shv[SW-1:thf_pkg::LN_W-1];
    if (nzp) begin
      ln_next = {1'b1, {(thf_pkg::LN_W-1){1'b0}}};
    end else if ((hi == '0) || (hi == '1)) begin
      ln_next = shv[thf_pkg::LN_W-1:0];
    end else if (shv[SW-1]) begin
      ln_next = {1'b1, {(thf_pkg::LN_W-1){1'b0}}};
    end else begin
      ln_next = {1'b0, {(thf_pkg::LN_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    diff   <= $signed({1'b0, en[N], fn[N]}) - $signed({1'b0, ed[N], fd[N]});
    fdiff  <= flg[N];
    nzd    <= nz[N];
    prod   <= thf_pkg::LN_PROD_W'(diff * $signed({1'b0, thf_pkg::LN2_Q32}));
    fprod  <= fdiff;
    nzp    <= nzd;
    ln     <= ln_next;
    fclamp <= fprod;
  end

  assign out_valid = vc;
  assign out_flags = fclamp;

endmodule

>>> rtl/thf_poly.sv
module thf_poly (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  thf_pkg::thf_flags_t in_flags,
  input  logic signed [thf_pkg::LN_W-1:0] ln,
  output logic out_valid,
  output thf_pkg::thf_flags_t out_flags,
  output logic signed [thf_pkg::T_W-1:0] t
);

  localparam int P_W = thf_pkg::T_W + thf_pkg::LN_W;

  // Three Horner steps, each a multiply stage then an add stage
  logic vm [0:2];
  logic va [0:2];
  thf_pkg::thf_flags_t fm [0:2];
  thf_pkg::thf_flags_t fa [0:2];
  logic signed [P_W-1:0] pm [0:2];
  logic signed [thf_pkg::T_W-1:0] ta [0:2];
  logic signed [thf_pkg::LN_W-1:0] lnm [0:2];
  logic signed [thf_pkg::LN_W-1:0] lna [0:1];
  logic signed [thf_pkg::T_W-1:0] mop [0:2];
  logic signed [thf_pkg::LN_W-1:0] lop [0:2];
  thf_pkg::thf_flags_t fop [0:2];
  logic vop [0:2];
  logic signed [thf_pkg::T_W-1:0] coef [0:2];

  always_comb begin
    coef[0] = thf_pkg::SH_C;
    coef[1] = thf_pkg::SH_B;
    coef[2] = thf_pkg::SH_A;
    mop[0]  = thf_pkg::SH_D;
    lop[0]  = ln;
    fop[0]  = in_flags;
    vop[0]  = in_valid;
    for (int k = 1; k < 3; k++) begin
      mop[k] = ta[k-1];
      lop[k] = lna[k-1];
      fop[k] = fa[k-1];
      vop[k] = va[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        vm[k] <= 1'b0;
        va[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        vm[k] <= vop[k];
        va[k] <= vm[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pm[k]  <= P_W'(mop[k] * lop[k]);
      lnm[k] <= lop[k];
      fm[k]  <= fop[k];
      ta[k]  <= thf_pkg::T_W'($signed(pm[k][P_W-1:thf_pkg::HORNER_SHIFT]) + coef[k]);
      fa[k]  <= fm[k];
    end
    for (int k = 0; k < 2; k++) lna[k] <= lnm[k];
  end

  assign out_valid = va[2];
  assign out_flags = fa[2];
  assign t         = ta[2];

endmodule

>>> rtl/thf_recip.sv
module thf_recip (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  thf_pkg::thf_flags_t in_flags,
  input  logic signed [thf_pkg::T_W-1:0] t,
  output logic out_valid,
  output thf_pkg::thf_flags_t out_flags,
  output logic [thf_pkg::Q_W-1:0] q
);

  localparam int N = thf_pkg::Q_W;

  // Restoring division, one quotient bit per stage; index 0 is the setup stage
  logic vld [0:N];
  thf_pkg::thf_flags_t flg [0:N];
  logic [thf_pkg::DVS_W-1:0] rr [0:N];
  logic [thf_pkg::DVS_W-1:0] dd [0:N-1];
  logic [N-1:0] qq [0:N];
  logic [thf_pkg::DVS_W:0] r2 [1:N];
  logic ge [1:N];
  logic small_t;
  logic vo;
  thf_pkg::thf_flags_t fo;

  // Quotient would reach 2^41 (or t not positive): saturate
  assign small_t = $signed(t) <= $signed({1'b0, thf_pkg::REM_INIT});

  always_comb begin
    for (int i = 1; i <= N; i++) begin
      r2[i] = {rr[i-1], 1'b0};
      ge[i] = r2[i] >= {1'b0, dd[i-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) vld[i] <= 1'b0;
      vo <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i <= N; i++) vld[i] <= vld[i-1];
      vo <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    flg[0]     <= '{open: in_flags.open, sat: in_flags.sat | small_t};
    rr[0]      <= thf_pkg::REM_INIT;
    dd[0]      <= t[thf_pkg::DVS_W-1:0];
    qq[0]      <= '0;
    for (int i = 1; i <= N; i++) begin
      flg[i] <= flg[i-1];
      rr[i]  <= ge[i] ? thf_pkg::DVS_W'(r2[i] - {1'b0, dd[i-1]})
                      : r2[i][thf_pkg::DVS_W-1:0];
      qq[i]  <= {qq[i-1][N-2:0], ge[i]};
    end
    for (int i = 1; i < N; i++) dd[i] <= dd[i-1];
    // Quotient above 2^40 also saturates
    fo <= '{open: flg[N].open,
            sat: flg[N].sat | (qq[N][N-1] & (qq[N][N-2:0] != '0))};
    q  <= qq[N];
  end

  assign out_valid = vo;
  assign out_flags = fo;

endmodule

>>> rtl/thf_fmt.sv
module thf_fmt (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  thf_pkg::thf_flags_t in_flags,
  input  logic [thf_pkg::Q_W-1:0] q,
  output logic out_valid,
  output logic signed [thf_pkg::OUT_W-1:0] temp,
  output logic [thf_pkg::DIG_W-1:0] tens,
  output logic [thf_pkg::DIG_W-1:0] units,
  output logic [thf_pkg::DIG_W-1:0] tenths,
  output logic open
);

  localparam int MW = thf_pkg::MAG_W;

  logic v1, v2, v3, v4, v5;

  // Stage 1: subtract the offset, round or truncate to hundredths/10 scale
  logic signed [thf_pkg::V_W-1:0] v;
  logic [thf_pkg::V_W-1:0] sum;
  logic [thf_pkg::V_W-17:0] w;
  logic neg1, sat1, open1;
  logic [thf_pkg::W_W-1:0] w1;

  assign v   = $signed({1'b0, q}) - $signed(thf_pkg::OFFSET_Q16);
  assign sum = v[thf_pkg::V_W-1] ? thf_pkg::V_W'(-v) : thf_pkg::V_W'(v) + thf_pkg::ROUND_Q16;
  assign w   = sum[thf_pkg::V_W-1:16];

  // Stage 2: magnitude in tenths, saturated, zero for an open sensor
  logic [16:0] w_div;
  logic [MW-1:0] mag2;
  logic neg2, open2;
  assign w_div = thf_pkg::div10(w1);

  // Stage 3..5: decimal digits
  logic [16:0] q1c, q2c, q3c;
  logic [MW-1:0] mag3, mag4;
  logic [9:0] q1_3, q1_4;
  logic [6:0] q2_4;
  logic [3:0] d0_4;
  logic neg3, neg4, open3, open4;
  logic [MW-1:0] q1x10;
  logic [9:0] q2x10;
  logic [6:0] q3x10;

  assign q1c   = thf_pkg::div10(17'(mag2));
  assign q2c   = thf_pkg::div10(17'(q1_3));
  assign q3c   = thf_pkg::div10(17'(q2_4));
  assign q1x10 = MW'(q1_3) * MW'(10);
  assign q2x10 = 10'(q2_4) * 10'd10;
  assign q3x10 = 7'(q3c[3:0]) * 7'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    neg1  <= v[thf_pkg::V_W-1];
    open1 <= in_flags.open;
    sat1  <= in_flags.sat |
             (!v[thf_pkg::V_W-1] && (w >= (thf_pkg::V_W-16)'(thf_pkg::W_LIMIT)));
    w1    <= w[thf_pkg::W_W-1:0];
    // stage 2
    if (open1) mag2 <= '0;
    else if (sat1) mag2 <= thf_pkg::TEMP_LIMIT;
    else mag2 <= w_div[MW-1:0];
    neg2  <= neg1 & ~sat1 & ~open1;
    open2 <= open1;
    // stage 3
    mag3  <= mag2;
    q1_3  <= q1c[9:0];
    neg3  <= neg2;
    open3 <= open2;
    // stage 4
    mag4  <= mag3;
    q1_4  <= q1_3;
    q2_4  <= q2c[6:0];
    d0_4  <= 4'(mag3 - q1x10);
    neg4  <= neg3;
    open4 <= open3;
    // stage 5: output register
    temp   <= neg4 ? -$signed({1'b0, mag4}) : $signed({1'b0, mag4});
    tenths <= thf_pkg::ASCII_ZERO + thf_pkg::DIG_W'(d0_4);
    units  <= thf_pkg::ASCII_ZERO + thf_pkg::DIG_W'(q1_4 - q2x10);
    tens   <= thf_pkg::ASCII_ZERO + thf_pkg::DIG_W'(q2_4 - q3x10);
    open   <= open4;
  end

  assign out_valid = v5;

endmodule
